### sv/arq_receive_window_top_assert.svh
// Assertion macros for the ARQ receive window block.
`ifndef ARQ_RECEIVE_WINDOW_TOP_ASSERT_SVH
`define ARQ_RECEIVE_WINDOW_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define ARQRW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define ARQRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARQRW_ASSERT_IMP(label, ante, cons, msg)
`define ARQRW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### sv/arqrw_pkg.sv
// Shared types and constants for the ARQ receive window block.
package arqrw_pkg;

    localparam int unsigned SEQ_W = 16;
    typedef logic [SEQ_W-1:0] seq_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'b1;

    // Operating modes
    localparam logic MODE_SR  = 1'b0;
    localparam logic MODE_GBN = 1'b1;

    localparam seq_t TOTAL_RESET = 16'd20;

    // Result kinds
    typedef enum logic {
        KIND_ACK     = 1'b0,
        KIND_DELIVER = 1'b1
    } kind_t;

    // One result item
    typedef struct packed {
        kind_t kind;
        seq_t  seq;
        logic  finished;
        logic  last;
    } result_t;

    // Engine status seen by the top level
    typedef struct packed {
        logic busy;
        logic done;
    } eng_status_t;

    // Result queue sizing
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = 2;
    localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

endpackage

### sv/arq_receive_window_top.sv
// Top level of the ARQ receive window: engine front end plus result queue.
// Receiver side of a sliding-window ARQ, selective repeat (mode 0) or go-back-N
// (mode 1). Push one sequence number per item; results come out of a queue in
// order, each an acknowledgement or an in-order delivery, with last marking the
// final result of an item and finished marking the one that ends the transfer.
// An item is classified and acknowledged when it is taken; in selective repeat,
// the slide sequencer in the engine then delivers the consecutive marked slots
// from the base in order, holding while the result queue is full. Full stays
// high while the slide runs or while the four-entry result queue is full. Once finished,
// items are taken and dropped. Write configuration only while the block is idle.
module arq_receive_window_top #(
    parameter int unsigned WINDOW = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [arqrw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arqrw_pkg::SEQ_W-1:0]     cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [arqrw_pkg::SEQ_W-1:0]     seq_number,
    output logic                            empty,
    input  logic                            pop,
    output logic                            kind,
    output logic [arqrw_pkg::SEQ_W-1:0]     seq_number_out,
    output logic                            finished,
    output logic                            last
);

    logic                   q_full;
    logic                   res_push;
    arqrw_pkg::result_t     res_item;
    arqrw_pkg::result_t     head;
    arqrw_pkg::eng_status_t eng_status;

    // Front end
    arqrw_engine #(
        .WINDOW (WINDOW)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_push      (push),
        .in_seq       (seq_number),
        .in_full      (full),
        .q_full       (q_full),
        .res_push     (res_push),
        .res_item     (res_item),
        .status       (eng_status)
    );

    // Result queue
    arqrw_result_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_item (res_item),
        .full    (q_full),
        .pop     (pop),
        .empty   (empty),
        .head    (head)
    );

    assign kind           = head.kind;
    assign seq_number_out = head.seq;
    assign finished       = head.finished;
    assign last           = head.last;

    // Checks
`include "arq_receive_window_top_assert.svh"
    `ARQRW_ASSERT_IMP(a_no_push_when_full, res_push, !q_full, "result pushed into full queue")
    `ARQRW_ASSERT_IMP(a_no_push_after_done, eng_status.done, !res_push, "result after finish")
    `ARQRW_ASSERT_IMP(a_finish_is_last, res_push && res_item.finished, res_item.last, "finish not last")
    `ARQRW_ASSERT_NEXT(a_done_sticky, eng_status.done, eng_status.done, "finished flag dropped")
    `ARQRW_ASSERT_IMP(a_full_while_busy, eng_status.busy, full, "input open during slide")

endmodule

### sv/arqrw_engine.sv
// Front end: takes arriving sequence numbers, classifies them and walks the window.
module arqrw_engine #(
    parameter int unsigned WINDOW = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [arqrw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [arqrw_pkg::SEQ_W-1:0]        cfg_data,
    input  logic                               in_push,
    input  arqrw_pkg::seq_t                    in_seq,
    output logic                               in_full,
    input  logic                               q_full,
    output logic                               res_push,
    output arqrw_pkg::result_t                 res_item,
    output arqrw_pkg::eng_status_t             status
);

    localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned DIFF_W = arqrw_pkg::SEQ_W + 1;
    localparam logic [SLOT_W:0]   WIN_EXT   = (SLOT_W+1)'(WINDOW);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [DIFF_W-1:0] WIN_DIFF  = DIFF_W'(WINDOW);

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [WINDOW-1:0] marks_t;

    typedef enum logic {
        ST_IDLE,
        ST_SLIDE
    } state_t;

    state_t          state_reg, state_next;
    arqrw_pkg::seq_t base_reg, base_next;
    slot_t           slot_reg, slot_next;
    marks_t          marks_reg, marks_next;
    logic            done_reg, done_next;
    logic            mode_reg;
    arqrw_pkg::seq_t total_reg;

    logic [DIFF_W-1:0] diff;
    logic              in_win;
    logic              below;
    logic [SLOT_W:0]   slot_sum;
    slot_t             seq_slot;
    marks_t            marks_set;
    marks_t            marks_clr;
    arqrw_pkg::seq_t   base_inc;
    arqrw_pkg::seq_t   gbn_base;
    slot_t             slot_inc;
    logic              more;
    logic              accept;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= arqrw_pkg::MODE_SR;
            total_reg <= arqrw_pkg::TOTAL_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                arqrw_pkg::REG_MODE:  mode_reg  <= cfg_data[0];
                arqrw_pkg::REG_TOTAL: total_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Window arithmetic
    always_comb
    begin
        diff     = {1'b0, in_seq} - {1'b0, base_reg};
        below    = diff[DIFF_W-1];
        in_win   = !diff[DIFF_W-1] && (diff < WIN_DIFF);
        slot_sum = {1'b0, slot_reg} + {1'b0, diff[SLOT_W-1:0]};
        if (slot_sum >= WIN_EXT)
            seq_slot = SLOT_W'(slot_sum - WIN_EXT);
        else
            seq_slot = slot_sum[SLOT_W-1:0];
        marks_set = marks_reg | (marks_t'(1) << seq_slot);
        marks_clr = marks_reg & ~(marks_t'(1) << slot_reg);
        base_inc  = base_reg + 16'd1;
        // base wraps to zero, so its slot does too
        if (base_reg == 16'hFFFF || slot_reg == SLOT_LAST)
            slot_inc = '0;
        else
            slot_inc = slot_reg + SLOT_W'(1);
        more = marks_clr[slot_inc];
    end

    assign in_full = (state_reg != ST_IDLE) || q_full;
    assign accept  = in_push && !in_full;

    // Classification and slide sequencer
    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        slot_next  = slot_reg;
        marks_next = marks_reg;
        done_next  = done_reg;
        gbn_base   = base_reg;
        res_push   = 1'b0;
        res_item.kind     = arqrw_pkg::KIND_ACK;
        res_item.seq      = in_seq;
        res_item.finished = 1'b0;
        res_item.last     = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !done_reg)
                begin
                    if (mode_reg == arqrw_pkg::MODE_SR)
                    begin
                        if (in_win)
                        begin
                            res_push      = 1'b1;
                            res_item.last = !marks_set[slot_reg];
                            marks_next    = marks_set;
                            if (marks_set[slot_reg])
                                state_next = ST_SLIDE;
                        end
                        else if (below)
                        begin
                            res_push = 1'b1;
                        end
                    end
                    else
                    begin
                        if (in_seq == base_reg)
                        begin
                            res_push  = 1'b1;
                            gbn_base  = base_inc;
                            base_next = base_inc;
                            slot_next = slot_inc;
                        end
                        else if (base_reg != '0)
                        begin
                            res_push     = 1'b1;
                            res_item.seq = base_reg - 16'd1;
                        end
                        res_item.finished = (gbn_base >= total_reg);
                        if (gbn_base >= total_reg)
                            done_next = 1'b1;
                    end
                end
            end
            ST_SLIDE:
            begin
                if (!q_full)
                begin
                    res_push          = 1'b1;
                    res_item.kind     = arqrw_pkg::KIND_DELIVER;
                    res_item.seq      = base_reg;
                    res_item.finished = (base_inc >= total_reg);
                    res_item.last     = (base_inc >= total_reg) || !more;
                    marks_next        = marks_clr;
                    base_next         = base_inc;
                    slot_next         = slot_inc;
                    if (base_inc >= total_reg)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (!more)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            slot_reg  <= '0;
            marks_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            slot_reg  <= slot_next;
            marks_reg <= marks_next;
            done_reg  <= done_next;
        end
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = done_reg;

endmodule

### sv/arqrw_result_fifo.sv
// Back end: short result queue that holds items until the consumer pops them.
module arqrw_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  arqrw_pkg::result_t wr_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output arqrw_pkg::result_t head
);

    arqrw_pkg::result_t                  slots [arqrw_pkg::FIFO_DEPTH];
    logic [arqrw_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [arqrw_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [arqrw_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic                                do_wr;
    logic                                do_rd;

    assign full  = (count_reg == arqrw_pkg::FIFO_CNT_W'(arqrw_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = pop && !empty;
    assign head  = slots[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots[wr_ptr_reg] <= wr_item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + arqrw_pkg::FIFO_PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + arqrw_pkg::FIFO_PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + arqrw_pkg::FIFO_CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - arqrw_pkg::FIFO_CNT_W'(1);
        end
    end

endmodule
